// File: rtl/rprt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rprt_pkg
// Shared constants and types of the reader progress rank tracker.
// ----------------------------------------------------------------------------
package rprt_pkg;

  // default sizes of the stores
  localparam int USER_COUNT_DEF = 65536;
  localparam int PAGE_COUNT_DEF = 1024;
  localparam int BLOCK_SIZE_DEF = 32;

  // field and counter widths
  localparam int USER_W = 16;
  localparam int PAGE_W = 10;
  localparam int CNT_W  = 17;

  // 1.0 in 16 fraction bits
  localparam logic [CNT_W-1:0] FRAC_ONE = 17'h10000;

  // item kinds carried on tuser
  localparam logic MODE_READ  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // divider request and response
  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] numer;
    logic [CNT_W-1:0] denom;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [CNT_W-1:0] quot;
  } div_rsp_t;

endpackage
`default_nettype wire

// File: rtl/reader_progress_rank_tracker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// reader_progress_rank_tracker
// Per-user page store with per-page and per-block reader counts; answers
// the share of other readers on lower pages.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over its three memories, with
// addresses up to max(USER_COUNT, PAGE_COUNT) - 1, and takes no word until
// it ends. One word is worked on at a time. A read word is ignored when its
// user or page is out of range or its page is zero; a first read adds a reader
// to the total and to its page's counts, and a user who had a page before is
// taken off that page and then added to the new one; each count update is a
// read-modify-write of the page count memory and of the block count memory,
// whose block index comes from a two-stage unit. A query for a user on page p
// reads the block counts below p and then the page counts of the partial block
// one per cycle, and a bit-serial divider works out the fraction. A query for a
// user who has not read, or who is the only reader, skips the scan and the
// divider. A finished result waits in the output register while the next word is taken.
// ----------------------------------------------------------------------------
module reader_progress_rank_tracker #(
  parameter int USER_COUNT = rprt_pkg::USER_COUNT_DEF,
  parameter int PAGE_COUNT = rprt_pkg::PAGE_COUNT_DEF,
  parameter int BLOCK_SIZE = rprt_pkg::BLOCK_SIZE_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // input word
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // [15:0] user_id, [25:16] page_number
  input  wire logic        s_axis_tuser,   // [0] mode
  // result word
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [23:0] m_axis_tdata    // [16:0] cheer_fraction
);

  localparam int UIW     = rprt_pkg::USER_W;
  localparam int PGW     = rprt_pkg::PAGE_W;
  localparam int CW      = rprt_pkg::CNT_W;
  localparam int UW      = $clog2(USER_COUNT);
  localparam int PW      = $clog2(PAGE_COUNT);
  localparam int NB      = (PAGE_COUNT + BLOCK_SIZE - 1) / BLOCK_SIZE;
  localparam int BW      = (NB > 1) ? $clog2(NB) : 1;
  localparam int CLR_LEN = (USER_COUNT > PAGE_COUNT) ? USER_COUNT : PAGE_COUNT;
  localparam int CLW     = $clog2(CLR_LEN);
  localparam int BASE_W  = $clog2((2 ** PGW) + BLOCK_SIZE);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_UREAD,
    S_ULOOK,
    S_ASTART,
    S_ACNT,
    S_ABLK,
    S_ABWR,
    S_SCANB,
    S_SCANP,
    S_DIVGO,
    S_DIVWAIT,
    S_EMIT
  } state_t;

  state_t             state;
  logic [CLW-1:0]     clr_addr;
  logic               mode_r;
  logic [UIW-1:0]     user_r;
  logic [PGW-1:0]     page_r;
  logic [PGW-1:0]     upage;
  logic [PGW-1:0]     adj_page;
  logic               adj_inc;
  logic [CW-1:0]      sum;
  logic [CW-1:0]      sum_next;
  logic [BASE_W-1:0]  base;
  logic [BASE_W-1:0]  pidx;
  logic [BW-1:0]      bidx;
  logic               bacc;
  logic               pacc;
  logic [CW-1:0]      result;
  logic [CW-1:0]      total;
  logic [CW-1:0]      out_data;

  logic [UW-1:0]      uaddr;
  logic               user_ok;
  logic               page_ok;
  logic               clr_user_en;
  logic               clr_page_en;
  logic               clr_blk_en;
  logic [BW-1:0]      bq;

  // user page memory
  logic [PGW-1:0]     pg_mem [USER_COUNT];
  logic [PGW-1:0]     pg_rdata;
  logic               pg_we;
  logic [UW-1:0]      pg_waddr;
  logic [PGW-1:0]     pg_wdata;

  // page count memory
  logic [CW-1:0]      cnt_mem [PAGE_COUNT];
  logic [CW-1:0]      cnt_rdata;
  logic [PW-1:0]      cnt_raddr;
  logic               cnt_we;
  logic [PW-1:0]      cnt_waddr;
  logic [CW-1:0]      cnt_wdata;

  // block count memory
  logic [CW-1:0]      blk_mem [NB];
  logic [CW-1:0]      blk_rdata;
  logic [BW-1:0]      blk_raddr;
  logic               blk_we;
  logic [BW-1:0]      blk_waddr;
  logic [CW-1:0]      blk_wdata;

  rprt_pkg::div_req_t div_req;
  rprt_pkg::div_rsp_t div_rsp;

  // range checks of the latched word
  assign uaddr   = UW'(user_r);
  assign user_ok = 32'(user_r) < 32'(USER_COUNT);
  assign page_ok = (page_r != '0) && (32'(page_r) < 32'(PAGE_COUNT));

  assign clr_user_en = 32'(clr_addr) < 32'(USER_COUNT);
  assign clr_page_en = 32'(clr_addr) < 32'(PAGE_COUNT);
  assign clr_blk_en  = 32'(clr_addr) < 32'(NB);

  // block index of the page under update
  rprt_blkdiv #(
    .BLOCK_SIZE (BLOCK_SIZE),
    .BW         (BW)
  ) u_blkdiv (
    .clk  (clk),
    .page (adj_page),
    .blk  (bq)
  );

  // memory port selection
  always_comb begin
    pg_we     = 1'b0;
    pg_waddr  = uaddr;
    pg_wdata  = page_r;
    cnt_we    = 1'b0;
    cnt_waddr = PW'(adj_page);
    cnt_wdata = adj_inc ? cnt_rdata + CW'(1) : cnt_rdata - CW'(1);
    cnt_raddr = (state == S_SCANP) ? PW'(pidx) : PW'(adj_page);
    blk_we    = 1'b0;
    blk_waddr = bq;
    blk_wdata = adj_inc ? blk_rdata + CW'(1) : blk_rdata - CW'(1);
    blk_raddr = (state == S_SCANB) ? bidx : bq;
    if (state == S_CLEAR) begin
      pg_we     = clr_user_en;
      pg_waddr  = UW'(clr_addr);
      pg_wdata  = '0;
      cnt_we    = clr_page_en;
      cnt_waddr = PW'(clr_addr);
      cnt_wdata = '0;
      blk_we    = clr_blk_en;
      blk_waddr = BW'(clr_addr);
      blk_wdata = '0;
    end else if (state == S_ULOOK) begin
      pg_we = (mode_r == rprt_pkg::MODE_READ) && user_ok && page_ok;
    end else if (state == S_ACNT) begin
      cnt_we = 1'b1;
    end else if (state == S_ABWR) begin
      blk_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pg_we) begin
      pg_mem[pg_waddr] <= pg_wdata;
    end
    pg_rdata <= pg_mem[uaddr];
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    cnt_rdata <= cnt_mem[cnt_raddr];
  end

  always_ff @(posedge clk) begin
    if (blk_we) begin
      blk_mem[blk_waddr] <= blk_wdata;
    end
    blk_rdata <= blk_mem[blk_raddr];
  end

  // running count of lower readers, cleared while the word is looked up
  always_comb begin
    sum_next = sum;
    if (state == S_ULOOK) begin
      sum_next = '0;
    end else if (bacc) begin
      sum_next = sum + blk_rdata;
    end else if (pacc) begin
      sum_next = sum + cnt_rdata;
    end
  end

  // fraction divider
  assign div_req.start = (state == S_DIVGO);
  assign div_req.numer = sum;
  assign div_req.denom = total - CW'(1);

  rprt_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr_addr      <= '0;
      total         <= '0;
      bacc          <= 1'b0;
      pacc          <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      sum <= sum_next;
      if (m_axis_tready && state != S_EMIT) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          if (32'(clr_addr) == 32'(CLR_LEN - 1)) begin
            state <= S_IDLE;
          end else begin
            clr_addr <= clr_addr + CLW'(1);
          end
        end
        S_IDLE: begin
          if (s_axis_tvalid) begin
            mode_r <= s_axis_tuser;
            user_r <= s_axis_tdata[UIW-1:0];
            page_r <= s_axis_tdata[UIW +: PGW];
            state  <= S_UREAD;
          end
        end
        S_UREAD: begin
          state <= S_ULOOK;
        end
        S_ULOOK: begin
          if (mode_r == rprt_pkg::MODE_QUERY) begin
            if (!user_ok || pg_rdata == '0) begin
              result <= '0;
              state  <= S_EMIT;
            end else if (total <= CW'(1)) begin
              result <= rprt_pkg::FRAC_ONE;
              state  <= S_EMIT;
            end else begin
              upage <= pg_rdata;
              base  <= '0;
              bidx  <= '0;
              bacc  <= 1'b0;
              pacc  <= 1'b0;
              state <= S_SCANB;
            end
          end else if (user_ok && page_ok) begin
            // first read adds a reader, a move takes the old page out first
            if (pg_rdata == '0) begin
              total    <= total + CW'(1);
              adj_page <= page_r;
              adj_inc  <= 1'b1;
            end else begin
              adj_page <= pg_rdata;
              adj_inc  <= 1'b0;
            end
            state <= S_ASTART;
          end else begin
            state <= S_IDLE;
          end
        end
        S_ASTART: begin
          state <= S_ACNT;
        end
        S_ACNT: begin
          state <= S_ABLK;
        end
        S_ABLK: begin
          state <= S_ABWR;
        end
        S_ABWR: begin
          if (adj_inc) begin
            state <= S_IDLE;
          end else begin
            adj_page <= page_r;
            adj_inc  <= 1'b1;
            state    <= S_ASTART;
          end
        end
        S_SCANB: begin
          // whole blocks below the user's page
          if (base + BASE_W'(BLOCK_SIZE) <= BASE_W'(upage)) begin
            bacc <= 1'b1;
            bidx <= bidx + BW'(1);
            base <= base + BASE_W'(BLOCK_SIZE);
          end else begin
            bacc  <= 1'b0;
            pidx  <= base;
            state <= S_SCANP;
          end
        end
        S_SCANP: begin
          // single pages of the partial block
          if (pidx < BASE_W'(upage)) begin
            pacc <= 1'b1;
            pidx <= pidx + BASE_W'(1);
          end else begin
            pacc  <= 1'b0;
            state <= S_DIVGO;
          end
        end
        S_DIVGO: begin
          state <= S_DIVWAIT;
        end
        S_DIVWAIT: begin
          if (div_rsp.done) begin
            result <= div_rsp.quot;
            state  <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            out_data      <= result;
            m_axis_tvalid <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tdata  = {7'd0, out_data};

endmodule
`default_nettype wire

// File: rtl/rprt_blkdiv.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rprt_blkdiv
// Two-stage page to block index unit: reciprocal multiply, then one
// correction step against the block size.
// ----------------------------------------------------------------------------
module rprt_blkdiv #(
  parameter int BLOCK_SIZE = rprt_pkg::BLOCK_SIZE_DEF,
  parameter int BW         = 5
) (
  input  wire logic                      clk,
  input  wire logic [rprt_pkg::PAGE_W-1:0] page,
  output logic      [BW-1:0]             blk
);

  localparam int PW    = rprt_pkg::PAGE_W;
  localparam int K     = PW + 1;
  localparam int MW    = K + 1;
  localparam int P1W   = PW + MW;
  localparam int P2W   = PW + 9;
  localparam logic [MW-1:0] RECIP = MW'((2 ** K) / BLOCK_SIZE);

  logic [P1W-1:0] prod1;
  logic [PW-1:0]  q0;
  logic [PW-1:0]  pg1;
  logic [P2W-1:0] prod2;
  logic [P2W-1:0] rem;
  logic [PW-1:0]  q;

  // estimate, never more than one below the true quotient
  assign prod1 = P1W'(page) * P1W'(RECIP);

  always_ff @(posedge clk) begin
    q0  <= prod1[K +: PW];
    pg1 <= page;
  end

  // correction by one compare
  assign prod2 = P2W'(q0) * P2W'(BLOCK_SIZE);
  assign rem   = P2W'(pg1) - prod2;
  assign q     = (rem >= P2W'(BLOCK_SIZE)) ? q0 + PW'(1) : q0;

  always_ff @(posedge clk) begin
    blk <= BW'(q);
  end

endmodule
`default_nettype wire

// File: rtl/rprt_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rprt_div
// Restoring divider for the rank fraction: floor(numer * 2^16 / denom),
// one quotient bit per cycle, clamped at 1.0.
// ----------------------------------------------------------------------------
module rprt_div (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire rprt_pkg::div_req_t req,
  output rprt_pkg::div_rsp_t      rsp
);

  localparam int CW  = rprt_pkg::CNT_W;
  localparam int NW  = $clog2(CW + 1);

  logic          busy;
  logic          done;
  logic [NW-1:0] cnt;
  logic [CW-1:0] rem;
  logic [CW-1:0] shin;
  logic [CW-1:0] quo;
  logic [CW-1:0] dvs;
  logic [CW:0]   t;
  logic [CW:0]   diff;
  logic          ge;

  // trial subtract of the shifted remainder
  assign t    = {rem, shin[CW-1]};
  assign diff = t - {1'b0, dvs};
  assign ge   = t >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      // last quotient bit lands at this edge
      done <= !req.start && busy && (cnt == NW'(1));
      if (req.start) begin
        // numerator shifted up 16: top 16 bits preload, then 17 bits shift in
        busy <= 1'b1;
        cnt  <= NW'(CW);
        rem  <= {1'b0, req.numer[CW-1:1]};
        shin <= {req.numer[0], (CW-1)'(0)};
        quo  <= '0;
        dvs  <= req.denom;
      end else if (busy) begin
        rem  <= ge ? diff[CW-1:0] : t[CW-1:0];
        shin <= {shin[CW-2:0], 1'b0};
        quo  <= {quo[CW-2:0], ge};
        cnt  <= cnt - NW'(1);
        if (cnt == NW'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // clamp at 1.0
  assign rsp.done = done;
  assign rsp.quot = (quo > rprt_pkg::FRAC_ONE) ? rprt_pkg::FRAC_ONE : quo;

endmodule
`default_nettype wire
